/* rtl/hcd_pkg.sv */
// Package for the chunked transfer decoder: parse modes, character codes and error codes.
package hcd_pkg;

  localparam int unsigned MaxSizeDigits = 16;
  localparam int unsigned DigitCntW    = $clog2(MaxSizeDigits + 1);
  localparam int unsigned SizeW        = 64;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_BAD_SIZE = 2'd2,
    ERR_AFTER_END = 2'd3
  } err_e;

  typedef enum logic [7:0] {
    MODE_SIZE      = 8'b0000_0001,
    MODE_EXT       = 8'b0000_0010,
    MODE_DATA      = 8'b0000_0100,
    MODE_DATA_CRLF = 8'b0000_1000,
    MODE_TRL_START = 8'b0001_0000,
    MODE_TRAILER   = 8'b0010_0000,
    MODE_END       = 8'b0100_0000,
    MODE_ERROR     = 8'b1000_0000
  } mode_e;

endpackage

/* rtl/http_chunked_decoder.sv */
// Chunked transfer decoder: strips chunk framing from a byte stream, one beat per cycle
// while the output is not stalled; each beat is registered at input and at output.
// Throughput: one beat per cycle; the input register feeds a single parse step that
// loads the result register, and both advance together while the output is not stalled.
// Reset: asynchronous, active low; clears both registers' valid bits and the parse state.
module http_chunked_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                payload_valid_o,
  output logic                chunk_last_o,
  output logic                stream_end_o,
  output hcd_pkg::err_e       error_code_o,
  output logic                missing_crlf_o
);
  import hcd_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 payload_valid_q;
  logic                 chunk_last_q;
  logic                 stream_end_q;
  err_e                 error_q;
  logic                 missing_q;

  mode_e                mode_q, mode_d;
  logic [SizeW-1:0]     acc_q, acc_d;
  logic [DigitCntW-1:0] dc_q, dc_d;
  logic [SizeW-1:0]     rem_q, rem_d;
  err_e                 err_q, err_d;
  logic                 crlf_q, crlf_d;

  logic                 out_load;
  logic                 take;
  logic [7:0]           c;
  logic                 hex_ok;
  logic [3:0]           hex_val;
  logic                 is_sep;
  logic                 do_size;
  logic                 end_line;
  logic [7:0]           obyte;
  logic                 pvalid;
  logic                 plast;
  logic                 send;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign take       = in_valid_q && out_load;
  assign in_stall_o = in_valid_q && !out_load;
  assign c          = in_byte_q;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_sep = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
                  (c == ChFf) || (c == ChCr) || (c == ChSemi);

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    dc_d     = dc_q;
    rem_d    = rem_q;
    err_d    = err_q;
    crlf_d   = crlf_q;
    do_size  = 1'b0;
    end_line = 1'b0;
    obyte    = 8'd0;
    pvalid   = 1'b0;
    plast    = 1'b0;
    send     = 1'b0;

    case (mode_q)
      MODE_SIZE: begin
        do_size = 1'b1;
      end
      MODE_EXT: begin
        if (c == ChLf) begin
          end_line = 1'b1;
        end
      end
      MODE_DATA: begin
        obyte  = c;
        pvalid = 1'b1;
        rem_d  = rem_q - 1'b1;
        if (rem_q == SizeW'(1)) begin
          plast  = 1'b1;
          mode_d = MODE_DATA_CRLF;
        end
      end
      MODE_DATA_CRLF: begin
        if (c == ChLf) begin
          mode_d = MODE_SIZE;
        end else if (c != ChCr) begin
          crlf_d  = 1'b1;
          mode_d  = MODE_SIZE;
          do_size = 1'b1;
        end
      end
      MODE_TRL_START: begin
        if (c == ChLf) begin
          mode_d = MODE_END;
          send   = 1'b1;
        end else if (c != ChCr) begin
          mode_d = MODE_TRAILER;
        end
      end
      MODE_TRAILER: begin
        if (c == ChLf) begin
          mode_d = MODE_TRL_START;
        end
      end
      MODE_END: begin
        err_d  = ERR_AFTER_END;
        mode_d = MODE_ERROR;
      end
      default: begin
      end
    endcase

    if (do_size) begin
      if (hex_ok) begin
        if (dc_q >= DigitCntW'(MaxSizeDigits)) begin
          err_d  = ERR_OVERFLOW;
          mode_d = MODE_ERROR;
        end else begin
          acc_d  = {acc_q[SizeW-5:0], hex_val};
          dc_d   = dc_q + 1'b1;
          mode_d = MODE_SIZE;
        end
      end else if (dc_q == '0 || !is_sep) begin
        err_d  = ERR_BAD_SIZE;
        mode_d = MODE_ERROR;
      end else if (c == ChLf) begin
        end_line = 1'b1;
      end else begin
        mode_d = MODE_EXT;
      end
    end

    if (end_line) begin
      rem_d  = acc_q;
      acc_d  = '0;
      dc_d   = '0;
      mode_d = (acc_q != '0) ? MODE_DATA : MODE_TRL_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_SIZE;
      acc_q       <= '0;
      dc_q        <= '0;
      rem_q       <= '0;
      err_q       <= ERR_NONE;
      crlf_q      <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (take) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      if (take) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        dc_q   <= dc_d;
        rem_q  <= rem_d;
        err_q  <= err_d;
        crlf_q <= crlf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
    if (take) begin
      out_byte_q      <= obyte;
      payload_valid_q <= pvalid;
      chunk_last_q    <= plast;
      stream_end_q    <= send;
      error_q         <= err_d;
      missing_q       <= crlf_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign payload_valid_o = payload_valid_q;
  assign chunk_last_o    = chunk_last_q;
  assign stream_end_o    = stream_end_q;
  assign error_code_o    = error_q;
  assign missing_crlf_o  = missing_q;

endmodule

/* rtl/hcd_checker.sv */
// Port-level checker for the chunked transfer decoder, bound to the top level.
module hcd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [7:0]          out_byte_o,
  input logic                payload_valid_o,
  input logic                chunk_last_o,
  input logic                stream_end_o,
  input hcd_pkg::err_e       error_code_o,
  input logic                missing_crlf_o
);
  import hcd_pkg::*;

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chunk_last_o) |-> payload_valid_o)
    else $error("chunk_last without payload_valid");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (out_byte_o == 8'd0))
    else $error("non-payload beat carries a byte");

  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ERR_NONE) |->
      (!payload_valid_o && !chunk_last_o && !stream_end_o))
    else $error("activity reported after an error");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ERR_NONE) |=> (error_code_o == $past(error_code_o)))
    else $error("latched error changed");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(payload_valid_o) &&
       $stable(missing_crlf_o)))
    else $error("stalled result beat changed");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .payload_valid_o (payload_valid_o),
  .chunk_last_o    (chunk_last_o),
  .stream_end_o    (stream_end_o),
  .error_code_o    (error_code_o),
  .missing_crlf_o  (missing_crlf_o)
);
